>>> src/subscription_match_table_core_macros.svh
// Assertion macros shared by the subscription match table sources.
`ifndef SUBSCRIPTION_MATCH_TABLE_CORE_MACROS_SVH
`define SUBSCRIPTION_MATCH_TABLE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("subscription match table check failed");

// The consequent must hold in the cycle after the antecedent.
`define SMT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("subscription match table check failed");

`endif

>>> src/smt_pkg.sv
// Types, sizes and codes shared by the subscription match table modules.
package smt_pkg;

    localparam int CLIENTS       = 64;
    localparam int SUBSCRIPTIONS = 256;
    localparam int HASH_BITS     = 32;
    localparam int MAX_RESULTS   = 64;

    localparam int SLOT_W   = $clog2(CLIENTS);
    localparam int SUB_W    = $clog2(SUBSCRIPTIONS);
    localparam int CNT_W    = (SLOT_W > SUB_W) ? SLOT_W : SUB_W;
    localparam int RES_W    = $clog2(MAX_RESULTS);
    localparam int OSLOT_W  = 6;
    localparam int STATUS_W = 3;
    localparam int SESS_W   = 16;

    localparam logic [1:0] FUNC_REGISTER    = 2'd0;
    localparam logic [1:0] FUNC_SUBSCRIBE   = 2'd1;
    localparam logic [1:0] FUNC_UNSUBSCRIBE = 2'd2;
    localparam logic [1:0] FUNC_PUBLISH     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd5;

    typedef logic [HASH_BITS-1:0] hash_t;

    typedef struct packed {
        logic              valid;
        hash_t             hash;
        logic [SESS_W-1:0] session;
    } client_entry_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        hash_t             name;
        hash_t             object;
        logic [SESS_W-1:0] session;
    } sub_entry_t;

endpackage

>>> src/smt_client_cell.sv
// One client table cell of the rotating client ring.
module smt_client_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   shift_en,
    input  smt_pkg::client_entry_t d,
    output smt_pkg::client_entry_t q
);

    logic                        valid_reg;
    smt_pkg::hash_t              hash_reg;
    logic [smt_pkg::SESS_W-1:0]  session_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            hash_reg    <= d.hash;
            session_reg <= d.session;
        end
    end

    assign q.valid   = valid_reg;
    assign q.hash    = hash_reg;
    assign q.session = session_reg;

endmodule

>>> src/smt_sub_cell.sv
// One subscription cell of the rotating subscription ring.
module smt_sub_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                shift_en,
    input  smt_pkg::sub_entry_t d,
    output smt_pkg::sub_entry_t q
);

    logic                        valid_reg;
    logic [smt_pkg::SLOT_W-1:0]  slot_reg;
    smt_pkg::hash_t              name_reg;
    smt_pkg::hash_t              object_reg;
    logic [smt_pkg::SESS_W-1:0]  session_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            slot_reg    <= d.slot;
            name_reg    <= d.name;
            object_reg  <= d.object;
            session_reg <= d.session;
        end
    end

    assign q.valid   = valid_reg;
    assign q.slot    = slot_reg;
    assign q.name    = name_reg;
    assign q.object  = object_reg;
    assign q.session = session_reg;

endmodule

>>> src/subscription_match_table_core.sv
// Publish/subscribe matcher: client ring, subscription ring and result sequencer.
// Register: a scan of the client ring, plus a write pass when a new slot is taken, then one result.
// Subscribe/unsubscribe: a client scan and a subscription scan, plus a write pass to add a new entry.
// Publish: a subscription scan, then one result per matching slot.
// The rings rotate one entry per cycle past a single compare point while a scan or write pass runs.
// Synchronous active-low reset clears all valid bits at once; no clearing pass is needed.
`include "subscription_match_table_core_macros.svh"

module subscription_match_table_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_func,
    input  logic [31:0]                   s_client_key,
    input  logic [15:0]                   s_session_id,
    input  logic [31:0]                   s_name_hash,
    input  logic [31:0]                   s_object_hash,
    input  logic                          s_post_all,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [smt_pkg::OSLOT_W-1:0]   m_client_slot,
    output logic [smt_pkg::STATUS_W-1:0]  m_status,
    output logic                          m_last_result
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CSCAN  = 3'd1;
    localparam logic [2:0] ST_CWRITE = 3'd2;
    localparam logic [2:0] ST_SSCAN  = 3'd3;
    localparam logic [2:0] ST_SWRITE = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;
    localparam logic [2:0] ST_FIN    = 3'd6;

    localparam int SLOT_W = smt_pkg::SLOT_W;
    localparam int SUB_W  = smt_pkg::SUB_W;
    localparam int CNT_W  = smt_pkg::CNT_W;
    localparam int RES_W  = smt_pkg::RES_W;
    localparam logic [CNT_W-1:0] C_LAST = CNT_W'(smt_pkg::CLIENTS - 1);
    localparam logic [CNT_W-1:0] S_LAST = CNT_W'(smt_pkg::SUBSCRIPTIONS - 1);
    localparam logic [RES_W-1:0] N_LAST = RES_W'(smt_pkg::MAX_RESULTS - 1);

    smt_pkg::client_entry_t c_q [smt_pkg::CLIENTS];
    smt_pkg::sub_entry_t    s_q [smt_pkg::SUBSCRIPTIONS];
    smt_pkg::client_entry_t c_tail;
    smt_pkg::sub_entry_t    s_tail;
    logic                   c_shift;
    logic                   s_shift;

    logic [2:0]                      st_reg, st_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [1:0]                      func_reg, func_next;
    smt_pkg::hash_t                  key_reg, key_next;
    logic [15:0]                     sess_reg, sess_next;
    smt_pkg::hash_t                  name_reg, name_next;
    smt_pkg::hash_t                  obj_reg, obj_next;
    logic                            all_reg, all_next;
    logic                            cfound_reg, cfound_next;
    logic [SLOT_W-1:0]               cslot_reg, cslot_next;
    logic [15:0]                     csess_reg, csess_next;
    logic                            cfree_found_reg, cfree_found_next;
    logic [SLOT_W-1:0]               cfree_slot_reg, cfree_slot_next;
    logic                            sfound_reg, sfound_next;
    logic                            sfree_found_reg, sfree_found_next;
    logic [SUB_W-1:0]                sfree_idx_reg, sfree_idx_next;
    logic [smt_pkg::CLIENTS-1:0]     hit_reg, hit_next;
    logic [RES_W-1:0]                emit_n_reg, emit_n_next;
    logic [SLOT_W-1:0]               res_slot_reg, res_slot_next;
    logic [smt_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic                            m_valid_reg, m_valid_next;
    logic [smt_pkg::OSLOT_W-1:0]     m_slot_reg, m_slot_next;
    logic [smt_pkg::STATUS_W-1:0]    m_status_reg, m_status_next;
    logic                            m_last_reg, m_last_next;

    smt_pkg::client_entry_t  c_head;
    smt_pkg::sub_entry_t     s_head;
    logic [SLOT_W-1:0]       cnt_slot;
    logic [SUB_W-1:0]        cnt_sub;
    logic                    c_hit;
    logic                    c_found_now;
    logic [SLOT_W-1:0]       c_slot_now;
    logic                    c_free_now;
    logic                    s_match;
    logic                    s_found_now;
    logic                    s_free_now;
    logic                    pub_hit;
    logic                    out_free;
    logic [smt_pkg::CLIENTS-1:0] rest;
    logic                    emit_last;

    genvar gi;
    generate
        for (gi = 0; gi < smt_pkg::CLIENTS; gi++) begin : g_client
            if (gi == smt_pkg::CLIENTS - 1) begin : g_tail
                smt_client_cell u_cell (
                    .aclk(aclk), .aresetn(aresetn), .shift_en(c_shift),
                    .d(c_tail), .q(c_q[gi])
                );
            end else begin : g_body
                smt_client_cell u_cell (
                    .aclk(aclk), .aresetn(aresetn), .shift_en(c_shift),
                    .d(c_q[gi+1]), .q(c_q[gi])
                );
            end
        end
        for (gi = 0; gi < smt_pkg::SUBSCRIPTIONS; gi++) begin : g_sub
            if (gi == smt_pkg::SUBSCRIPTIONS - 1) begin : g_tail
                smt_sub_cell u_cell (
                    .aclk(aclk), .aresetn(aresetn), .shift_en(s_shift),
                    .d(s_tail), .q(s_q[gi])
                );
            end else begin : g_body
                smt_sub_cell u_cell (
                    .aclk(aclk), .aresetn(aresetn), .shift_en(s_shift),
                    .d(s_q[gi+1]), .q(s_q[gi])
                );
            end
        end
    endgenerate

    assign c_head   = c_q[0];
    assign s_head   = s_q[0];
    assign cnt_slot = cnt_reg[SLOT_W-1:0];
    assign cnt_sub  = cnt_reg[SUB_W-1:0];
    assign c_shift  = (st_reg == ST_CSCAN) || (st_reg == ST_CWRITE);
    assign s_shift  = (st_reg == ST_SSCAN) || (st_reg == ST_SWRITE);
    assign out_free = !m_valid_reg || m_ready;

    assign c_hit       = c_head.valid && (c_head.hash == key_reg);
    assign c_found_now = cfound_reg || c_hit;
    assign c_slot_now  = cfound_reg ? cslot_reg : cnt_slot;
    assign c_free_now  = cfree_found_reg || !c_head.valid;

    assign s_match = s_head.valid && (s_head.slot == cslot_reg) &&
                     (s_head.name == name_reg) && (s_head.object == obj_reg);
    assign s_found_now = sfound_reg || s_match;
    assign s_free_now  = sfree_found_reg || !s_head.valid;
    assign pub_hit = s_head.valid &&
                     ((s_head.name == '0) || (s_head.name == name_reg)) &&
                     ((s_head.object == '0) || (s_head.object == obj_reg)) &&
                     (all_reg || (s_head.session == sess_reg));

    always_comb begin
        rest = hit_reg;
        rest[cnt_slot] = 1'b0;
        emit_last = (rest == '0) || (emit_n_reg == N_LAST);
    end

    always_comb begin
        c_tail = c_head;
        if (st_reg == ST_CSCAN && func_reg == smt_pkg::FUNC_REGISTER && c_hit) begin
            c_tail.session = sess_reg;
        end
        if (st_reg == ST_CWRITE && cnt_slot == cfree_slot_reg) begin
            c_tail.valid   = 1'b1;
            c_tail.hash    = key_reg;
            c_tail.session = sess_reg;
        end
    end

    always_comb begin
        s_tail = s_head;
        if (st_reg == ST_SSCAN && func_reg == smt_pkg::FUNC_UNSUBSCRIBE &&
            s_match && !sfound_reg) begin
            s_tail.valid = 1'b0;
        end
        if (st_reg == ST_SWRITE && cnt_sub == sfree_idx_reg) begin
            s_tail.valid   = 1'b1;
            s_tail.slot    = cslot_reg;
            s_tail.name    = name_reg;
            s_tail.object  = obj_reg;
            s_tail.session = csess_reg;
        end
    end

    always_comb begin
        st_next          = st_reg;
        cnt_next         = cnt_reg;
        func_next        = func_reg;
        key_next         = key_reg;
        sess_next        = sess_reg;
        name_next        = name_reg;
        obj_next         = obj_reg;
        all_next         = all_reg;
        cfound_next      = cfound_reg;
        cslot_next       = cslot_reg;
        csess_next       = csess_reg;
        cfree_found_next = cfree_found_reg;
        cfree_slot_next  = cfree_slot_reg;
        sfound_next      = sfound_reg;
        sfree_found_next = sfree_found_reg;
        sfree_idx_next   = sfree_idx_reg;
        hit_next         = hit_reg;
        emit_n_next      = emit_n_reg;
        res_slot_next    = res_slot_reg;
        res_status_next  = res_status_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_slot_next      = m_slot_reg;
        m_status_next    = m_status_reg;
        m_last_next      = m_last_reg;

        unique case (st_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next        = s_func;
                    key_next         = smt_pkg::hash_t'(s_client_key);
                    sess_next        = s_session_id;
                    name_next        = smt_pkg::hash_t'(s_name_hash);
                    obj_next         = smt_pkg::hash_t'(s_object_hash);
                    all_next         = s_post_all;
                    cfound_next      = 1'b0;
                    cfree_found_next = 1'b0;
                    sfound_next      = 1'b0;
                    sfree_found_next = 1'b0;
                    hit_next         = '0;
                    cnt_next         = '0;
                    st_next = (s_func == smt_pkg::FUNC_PUBLISH) ? ST_SSCAN : ST_CSCAN;
                end
            end
            ST_CSCAN: begin
                cnt_next = CNT_W'(cnt_reg + 1'b1);
                if (c_hit && !cfound_reg) begin
                    cfound_next = 1'b1;
                    cslot_next  = cnt_slot;
                    csess_next  = c_head.session;
                end
                if (!c_head.valid && !cfree_found_reg) begin
                    cfree_found_next = 1'b1;
                    cfree_slot_next  = cnt_slot;
                end
                if (cnt_reg == C_LAST) begin
                    cnt_next = '0;
                    if (func_reg == smt_pkg::FUNC_REGISTER) begin
                        if (c_found_now) begin
                            res_slot_next   = c_slot_now;
                            res_status_next = smt_pkg::ST_UPDATED;
                            st_next         = ST_FIN;
                        end else if (c_free_now) begin
                            st_next = ST_CWRITE;
                        end else begin
                            res_slot_next   = '0;
                            res_status_next = smt_pkg::ST_FULL;
                            st_next         = ST_FIN;
                        end
                    end else if (!c_found_now) begin
                        res_slot_next   = '0;
                        res_status_next = smt_pkg::ST_UNKNOWN;
                        st_next         = ST_FIN;
                    end else begin
                        st_next = ST_SSCAN;
                    end
                end
            end
            ST_CWRITE: begin
                cnt_next = CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == C_LAST) begin
                    cnt_next        = '0;
                    res_slot_next   = cfree_slot_reg;
                    res_status_next = smt_pkg::ST_OK;
                    st_next         = ST_FIN;
                end
            end
            ST_SSCAN: begin
                cnt_next = CNT_W'(cnt_reg + 1'b1);
                if (func_reg == smt_pkg::FUNC_PUBLISH && pub_hit) begin
                    hit_next[s_head.slot] = 1'b1;
                end
                if (s_match && !sfound_reg) begin
                    sfound_next = 1'b1;
                end
                if (!s_head.valid && !sfree_found_reg) begin
                    sfree_found_next = 1'b1;
                    sfree_idx_next   = cnt_sub;
                end
                if (cnt_reg == S_LAST) begin
                    cnt_next = '0;
                    if (func_reg == smt_pkg::FUNC_PUBLISH) begin
                        if (hit_next == '0) begin
                            res_slot_next   = '0;
                            res_status_next = smt_pkg::ST_NO_MATCH;
                            st_next         = ST_FIN;
                        end else begin
                            emit_n_next = '0;
                            st_next     = ST_EMIT;
                        end
                    end else if (func_reg == smt_pkg::FUNC_UNSUBSCRIBE) begin
                        res_slot_next   = cslot_reg;
                        res_status_next = s_found_now ? smt_pkg::ST_OK : smt_pkg::ST_DUP;
                        st_next         = ST_FIN;
                    end else if (s_found_now) begin
                        res_slot_next   = cslot_reg;
                        res_status_next = smt_pkg::ST_DUP;
                        st_next         = ST_FIN;
                    end else if (s_free_now) begin
                        st_next = ST_SWRITE;
                    end else begin
                        res_slot_next   = cslot_reg;
                        res_status_next = smt_pkg::ST_FULL;
                        st_next         = ST_FIN;
                    end
                end
            end
            ST_SWRITE: begin
                cnt_next = CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == S_LAST) begin
                    cnt_next        = '0;
                    res_slot_next   = cslot_reg;
                    res_status_next = smt_pkg::ST_OK;
                    st_next         = ST_FIN;
                end
            end
            ST_EMIT: begin
                if (hit_reg[cnt_slot]) begin
                    if (out_free) begin
                        m_valid_next       = 1'b1;
                        m_slot_next        = smt_pkg::OSLOT_W'(cnt_slot);
                        m_status_next      = smt_pkg::ST_OK;
                        m_last_next        = emit_last;
                        hit_next[cnt_slot] = 1'b0;
                        emit_n_next        = RES_W'(emit_n_reg + 1'b1);
                        cnt_next           = CNT_W'(cnt_reg + 1'b1);
                        if (emit_last) begin
                            st_next = ST_IDLE;
                        end
                    end
                end else begin
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_slot_next   = smt_pkg::OSLOT_W'(res_slot_reg);
                    m_status_next = res_status_reg;
                    m_last_next   = 1'b1;
                    st_next       = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg         <= cnt_next;
        func_reg        <= func_next;
        key_reg         <= key_next;
        sess_reg        <= sess_next;
        name_reg        <= name_next;
        obj_reg         <= obj_next;
        all_reg         <= all_next;
        cfound_reg      <= cfound_next;
        cslot_reg       <= cslot_next;
        csess_reg       <= csess_next;
        cfree_found_reg <= cfree_found_next;
        cfree_slot_reg  <= cfree_slot_next;
        sfound_reg      <= sfound_next;
        sfree_found_reg <= sfree_found_next;
        sfree_idx_reg   <= sfree_idx_next;
        hit_reg         <= hit_next;
        emit_n_reg      <= emit_n_next;
        res_slot_reg    <= res_slot_next;
        res_status_reg  <= res_status_next;
        m_slot_reg      <= m_slot_next;
        m_status_reg    <= m_status_next;
        m_last_reg      <= m_last_next;
    end

    assign s_ready       = (st_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_client_slot = m_slot_reg;
    assign m_status      = m_status_reg;
    assign m_last_result = m_last_reg;

    `SMT_ASSERT_NXT(a_accept_starts_scan, aclk, aresetn, s_valid && s_ready, st_reg == ST_CSCAN || st_reg == ST_SSCAN)
    `SMT_ASSERT_IMP(a_emit_has_hits, aclk, aresetn, st_reg == ST_EMIT, hit_reg != '0)
    `SMT_ASSERT_IMP(a_cwrite_new_key, aclk, aresetn, st_reg == ST_CWRITE, !cfound_reg && cfree_found_reg)

endmodule
